// ===== rtl/csf_pkg.sv =====
package csf_pkg;

    // Depth of the wait queue, one cell per thread slot
    localparam int MAX_THREADS = 16;
    localparam int FILL_W      = $clog2(MAX_THREADS + 1);

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int TID_W    = 4;
    localparam int INIT_W   = 10;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 12;

    // Count saturation limits
    localparam logic signed [CNT_W-1:0] CNT_MAX = 12'sh7FF;
    localparam logic signed [CNT_W-1:0] CNT_MIN = 12'sh800;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_WAIT   = 2'd1,
        OP_POST   = 2'd2,
        OP_FREE   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FREE_ERR = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // Control broadcast to every queue cell
    typedef struct packed {
        logic             shift;  // pop: every cell takes its right neighbor
        logic             push;   // append at the cell addressed by the fill count
        logic [TID_W-1:0] id;     // id written on push
    } t_cell_ctl;

endpackage

// ===== rtl/csf_cell.sv =====
module csf_cell
    import csf_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic             i_sel,      // this cell is the tail slot
    input  logic [TID_W-1:0] i_next_id,  // id held by the right neighbor
    output logic [TID_W-1:0] o_id
);

    logic [TID_W-1:0] r_id;
    logic [TID_W-1:0] n_id;

    // Shift toward the head on pop, load on push into the tail slot
    always_comb begin
        n_id = r_id;
        if (i_ctl.shift) begin
            n_id = i_next_id;
        end else if (i_ctl.push && i_sel) begin
            n_id = i_ctl.id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_id = r_id;

endmodule

// ===== rtl/counting_semaphore_fifo.sv =====
// Counting semaphore with a FIFO wait queue held in a shifting row of cells.
// Results are held in a registered output slot. Create, wait and post take a
// new item as the last result is taken; free with N waiters gives N results,
// one per cycle while the output is not stalled, and takes no item till done.
// Reset (synchronous, active low) clears the count, marks the semaphore free
// and empties the queue; the queue cells themselves are not cleared.
module counting_semaphore_fifo
    import csf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [TID_W-1:0]    i_thread_id,
    input  logic [INIT_W-1:0]   i_init_count,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_blocked,
    output logic                o_resumed_valid,
    output logic [TID_W-1:0]    o_resumed_thread,
    output logic                o_last
);

    // Semaphore state
    logic signed [CNT_W-1:0] r_count, n_count;
    logic                    r_in_use, n_in_use;
    logic [FILL_W-1:0]       r_fill, n_fill;
    logic                    r_drain, n_drain;

    // Output register
    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;
    logic                r_blocked, n_blocked;
    logic                r_rv, n_rv;
    logic [TID_W-1:0]    r_rt, n_rt;
    logic                r_last, n_last;

    t_cell_ctl           w_ctl;
    logic [TID_W-1:0]    w_id [MAX_THREADS];
    logic                w_slot_free;
    logic                w_accept;
    t_op                 w_op;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_drain && w_slot_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_op        = t_op'(i_op);

    // Row of queue cells, head at index 0
    for (genvar g = 0; g < MAX_THREADS; g++) begin : g_cell
        logic [TID_W-1:0] w_next;
        if (g == MAX_THREADS - 1) begin : g_end
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_id[g+1];
        end
        csf_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_sel     (r_fill == FILL_W'(g)),
            .i_next_id (w_next),
            .o_id      (w_id[g])
        );
    end

    // Operation decode and next state
    always_comb begin
        n_count     = r_count;
        n_in_use    = r_in_use;
        n_fill      = r_fill;
        n_drain     = r_drain;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_blocked   = r_blocked;
        n_rv        = r_rv;
        n_rt        = r_rt;
        n_last      = r_last;
        w_ctl.shift = 1'b0;
        w_ctl.push  = 1'b0;
        w_ctl.id    = i_thread_id;

        if (r_drain) begin
            // free in progress: one waiter per cycle while the output slot is free
            if (w_slot_free) begin
                w_ctl.shift = 1'b1;
                n_fill      = r_fill - 1'b1;
                n_out_valid = 1'b1;
                n_status    = ST_OK;
                n_blocked   = 1'b0;
                n_rv        = 1'b1;
                n_rt        = w_id[0];
                n_last      = (r_fill == FILL_W'(1));
                if (r_fill == FILL_W'(1)) begin
                    n_drain  = 1'b0;
                    n_in_use = 1'b0;
                end
            end
        end else if (w_accept) begin
            n_out_valid = 1'b1;
            n_status    = ST_OK;
            n_blocked   = 1'b0;
            n_rv        = 1'b0;
            n_rt        = '0;
            n_last      = 1'b1;
            if (w_op == OP_CREATE) begin
                n_count  = CNT_W'(i_init_count);
                n_in_use = 1'b1;
                n_fill   = '0;
            end else if (!r_in_use) begin
                n_status = ST_FREE_ERR;
            end else begin
                case (w_op)
                    OP_WAIT: begin
                        if (r_count > 0) begin
                            n_count = r_count - 1'b1;
                        end else if (r_fill == FILL_W'(MAX_THREADS)) begin
                            n_status = ST_OVERFLOW;
                        end else begin
                            if (r_count != CNT_MIN) begin
                                n_count = r_count - 1'b1;
                            end
                            w_ctl.push = 1'b1;
                            n_fill     = r_fill + 1'b1;
                            n_blocked  = 1'b1;
                        end
                    end
                    OP_POST: begin
                        if (r_count != CNT_MAX) begin
                            n_count = r_count + 1'b1;
                        end
                        // count stays at or below zero only if it was negative
                        if (r_count < 0 && r_fill != '0) begin
                            w_ctl.shift = 1'b1;
                            n_fill      = r_fill - 1'b1;
                            n_rv        = 1'b1;
                            n_rt        = w_id[0];
                        end
                    end
                    OP_FREE: begin
                        if (r_fill == '0) begin
                            n_in_use = 1'b0;
                        end else begin
                            w_ctl.shift = 1'b1;
                            n_fill      = r_fill - 1'b1;
                            n_rv        = 1'b1;
                            n_rt        = w_id[0];
                            n_last      = (r_fill == FILL_W'(1));
                            if (r_fill == FILL_W'(1)) begin
                                n_in_use = 1'b0;
                            end else begin
                                n_drain = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_in_use    <= 1'b0;
            r_fill      <= '0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_in_use    <= n_in_use;
            r_fill      <= n_fill;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_blocked <= n_blocked;
        r_rv      <= n_rv;
        r_rt      <= n_rt;
        r_last    <= n_last;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_blocked        = r_blocked;
    assign o_resumed_valid  = r_rv;
    assign o_resumed_thread = r_rt;
    assign o_last           = r_last;

endmodule

// ===== tb/sv/counting_semaphore_fifo_test.sv =====
`timescale 1ns / 100ps

module counting_semaphore_fifo_test;
    import csf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int END_CYCLES     = 8;

    // One result item as the block should present it
    typedef struct {
        t_status          status;
        logic             blocked;
        logic             resumed_valid;
        logic [TID_W-1:0] resumed_thread;
        logic             last;
    } t_sem_result;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic [OP_W-1:0]     i_op         = '0;
    logic [TID_W-1:0]    i_thread_id  = '0;
    logic [INIT_W-1:0]   i_init_count = '0;
    logic                i_out_ready  = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic                o_blocked;
    logic                o_resumed_valid;
    logic [TID_W-1:0]    o_resumed_thread;
    logic                o_last;

    // Shadow semaphore state
    logic signed [CNT_W-1:0] shadow_count;
    logic                    shadow_in_use;
    logic [TID_W-1:0]        shadow_waiters[$];
    t_sem_result             pending_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int err_count      = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int overflow_seen  = 0;
    int resumes_seen   = 0;

    counting_semaphore_fifo u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_thread_id      (i_thread_id),
        .i_init_count     (i_init_count),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_blocked        (o_blocked),
        .o_resumed_valid  (o_resumed_valid),
        .o_resumed_thread (o_resumed_thread),
        .o_last           (o_last)
    );

    always #1 i_clk = ~i_clk;

    function automatic void push_result(t_status st, logic blk, logic rv,
                                        logic [TID_W-1:0] rt, logic lst);
        t_sem_result r;
        r.status         = st;
        r.blocked        = blk;
        r.resumed_valid  = rv;
        r.resumed_thread = rt;
        r.last           = lst;
        pending_results.push_back(r);
    endfunction

    // Advance the shadow semaphore by one accepted item
    function automatic void predict_semaphore(t_op op, logic [TID_W-1:0] tid,
                                              logic [INIT_W-1:0] init);
        logic [TID_W-1:0] id;
        if (op == OP_CREATE) begin
            shadow_count  = $signed({{(CNT_W-INIT_W){1'b0}}, init});
            shadow_in_use = 1'b1;
            shadow_waiters.delete();
            push_result(ST_OK, 1'b0, 1'b0, '0, 1'b1);
        end else if (!shadow_in_use) begin
            push_result(ST_FREE_ERR, 1'b0, 1'b0, '0, 1'b1);
        end else if (op == OP_WAIT) begin
            if (shadow_count > 0) begin
                shadow_count = shadow_count - CNT_W'(1);
                push_result(ST_OK, 1'b0, 1'b0, '0, 1'b1);
            end else if (shadow_waiters.size() >= MAX_THREADS) begin
                overflow_seen++;
                push_result(ST_OVERFLOW, 1'b0, 1'b0, '0, 1'b1);
            end else begin
                if (shadow_count > CNT_MIN)
                    shadow_count = shadow_count - CNT_W'(1);
                shadow_waiters.push_back(tid);
                push_result(ST_OK, 1'b1, 1'b0, '0, 1'b1);
            end
        end else if (op == OP_POST) begin
            if (shadow_count < CNT_MAX)
                shadow_count = shadow_count + CNT_W'(1);
            if (shadow_count <= 0 && shadow_waiters.size() > 0) begin
                id = shadow_waiters.pop_front();
                resumes_seen++;
                push_result(ST_OK, 1'b0, 1'b1, id, 1'b1);
            end else begin
                push_result(ST_OK, 1'b0, 1'b0, '0, 1'b1);
            end
        end else begin
            // free: one result per drained waiter
            if (shadow_waiters.size() == 0) begin
                push_result(ST_OK, 1'b0, 1'b0, '0, 1'b1);
            end else begin
                while (shadow_waiters.size() > 0) begin
                    id = shadow_waiters.pop_front();
                    resumes_seen++;
                    push_result(ST_OK, 1'b0, 1'b1, id, shadow_waiters.size() == 0);
                end
            end
            shadow_in_use = 1'b0;
        end
    endfunction

    // Offer one item, with random idle cycles ahead of it; called at a rising edge
    task automatic send_item(t_op op, logic [TID_W-1:0] tid, logic [INIT_W-1:0] init);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_thread_id  <= tid;
        i_init_count <= init;
        do @(posedge i_clk); while (!o_in_ready);
        predict_semaphore(op, tid, init);
        items_sent++;
    endtask

    function automatic logic [INIT_W-1:0] pick_init();
        if ($urandom_range(99) < 70)
            return INIT_W'($urandom_range(3));
        return INIT_W'($urandom_range(1023));
    endfunction

    // Mostly well-formed semaphore traffic, some ops on a free semaphore
    task automatic random_item();
        int r;
        int n;
        r = $urandom_range(99);
        if (!shadow_in_use) begin
            if (r < 85)
                send_item(OP_CREATE, TID_W'($urandom), pick_init());
            else
                send_item(t_op'($urandom_range(1, 3)), TID_W'($urandom), INIT_W'($urandom));
        end else if (r < 48) begin
            send_item(OP_WAIT, TID_W'($urandom), INIT_W'($urandom));
        end else if (r < 86) begin
            send_item(OP_POST, TID_W'($urandom), INIT_W'($urandom));
        end else if (r < 92) begin
            send_item(OP_FREE, TID_W'($urandom), INIT_W'($urandom));
        end else if (r < 97) begin
            send_item(OP_CREATE, TID_W'($urandom), pick_init());
        end else begin
            // wait burst, often long enough to fill the queue
            n = $urandom_range(10, 18);
            repeat (n) send_item(OP_WAIT, TID_W'($urandom), INIT_W'($urandom));
        end
    endtask

    task automatic run_random(int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) random_item();
    endtask

    // Stop offering items and let every expected result drain; called at a rising edge
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Wait, post and free on a semaphore that was never created
    task automatic test_free_semaphore_errors();
        send_item(OP_WAIT, 4'd15, 10'd1023);
        send_item(OP_POST, 4'd0, 10'd0);
        send_item(OP_FREE, 4'd7, 10'd0);
    endtask

    // Fill the queue to the brim, overflow it, resume, drain, reload
    task automatic test_queue_overflow_and_drain();
        send_item(OP_CREATE, 4'd0, 10'd0);
        for (int k = 0; k < MAX_THREADS; k++)
            send_item(OP_WAIT, TID_W'(MAX_THREADS - 1 - k), INIT_W'(k));
        send_item(OP_WAIT, 4'd15, 10'd0);
        send_item(OP_POST, 4'd0, 10'd0);
        send_item(OP_FREE, 4'd0, 10'd0);
        send_item(OP_CREATE, 4'd0, 10'd1023);
        send_item(OP_WAIT, 4'd9, 10'd0);
        wait_for_results();
        send_item(OP_CREATE, 4'd0, 10'd2);
        send_item(OP_FREE, 4'd0, 10'd0);
    endtask

    // Random traffic under each idling mix
    task automatic test_random_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;  run_random(95);
        send_idle_pct = 62; recv_stall_pct = 0;  run_random(90);
        send_idle_pct = 0;  recv_stall_pct = 62; run_random(95);
        send_idle_pct = 22; recv_stall_pct = 22; run_random(90);
        send_idle_pct = 0;  recv_stall_pct = 0;
    endtask

    // Receiver holds off while items keep coming, so the input stalls
    task automatic test_output_backpressure();
        wait_for_results();
        hold_req = HOLD_CYCLES;
        @(posedge i_clk);
        send_item(OP_CREATE, 4'd0, 10'd1);
        repeat (40) random_item();
    endtask

    // Receiver: random stalls, plus a long hold-off when asked
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_sem_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: status %0d resumed %0d/%0d",
                       o_status, o_resumed_valid, o_resumed_thread);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    err_count++;
                end
                if (o_blocked !== want.blocked) begin
                    $error("blocked: expected %0d, actual %0d", want.blocked, o_blocked);
                    err_count++;
                end
                if (o_resumed_valid !== want.resumed_valid) begin
                    $error("resumed_valid: expected %0d, actual %0d",
                           want.resumed_valid, o_resumed_valid);
                    err_count++;
                end
                if (o_resumed_thread !== want.resumed_thread) begin
                    $error("resumed_thread: expected %0d, actual %0d",
                           want.resumed_thread, o_resumed_thread);
                    err_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, o_last);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: too long without any handshake ends the run
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("counting_semaphore_fifo: mismatch");
        $finish;
    end

    initial begin
        shadow_count  = '0;
        shadow_in_use = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_free_semaphore_errors();
        test_queue_overflow_and_drain();
        test_random_phases();
        test_output_backpressure();

        wait_for_results();
        repeat (END_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            err_count++;
        end

        $display("covered: %0d items, %0d results, %0d queue overflows, %0d resumes",
                 items_sent, results_seen, overflow_seen, resumes_seen);
        $display("covered: ops on a free semaphore, full-queue drain, idle/stall mixes, hold-off");
        if (err_count == 0)
            $display("counting_semaphore_fifo: match");
        else
            $display("counting_semaphore_fifo: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/csf_pkg.sv
rtl/csf_cell.sv
rtl/counting_semaphore_fifo.sv
tb/sv/counting_semaphore_fifo_test.sv
